### src/tcw_pkg.sv
package tcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int FIXED_ROWS = 2;
  localparam int CELLS      = COLS * ROWS;

  localparam int COL_W     = $clog2(COLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int IDX_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int DATA_W    = 16;
  localparam int COLOR_W   = 4;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;

  // scroll region: copy source is one row below the destination
  localparam int  COPY_FIRST  = FIXED_ROWS * COLS;
  localparam int  COPY_LAST   = (ROWS - 1) * COLS - 1;
  localparam int  BLANK_FIRST = (ROWS - 1) * COLS;
  localparam bit  HAS_COPY    = (FIXED_ROWS + 1) < ROWS;

  // idx / COLS as multiply by reciprocal, exact for any IDX_W-bit index
  localparam int      DIV_SHIFT = IDX_W + COL_W;
  localparam longint  DIV_MUL   = ((64'd1 << DIV_SHIFT) + COLS - 1) / COLS;
  localparam int      PROD_W    = DIV_SHIFT + IDX_W;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CURSOR = 2'd3
  } mode_t;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FILL   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_BLANK  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

endpackage

### src/text_console_writer_core.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  mode, char_code, cell_index
// output    out        out_valid/out_stall  cursor_pos, read_cell
// config    in         cfg_we               cfg_index, cfg_data
//
// Ordinary put, backspace, read and set cursor: the word is accepted in S_IDLE,
// then S_RESP takes the registered screen RAM read / result load.
// Clear: one RAM write per cell in S_FILL, then S_RESP.
// Scroll: one RAM copy per cell of the scroll region plus one write per cell
// of the bottom row. After reset the screen RAM is zeroed, one cell a cycle,
// with input stalled. A result waiting on out_stall holds the next word in
// S_RESP.
module text_console_writer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcw_pkg::MODE_W-1:0]     mode,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcw_pkg::IDX_W-1:0]      cursor_pos,
  output logic [tcw_pkg::DATA_W-1:0]     read_cell,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data
);

  tcw_pkg::state_t                state;
  logic [tcw_pkg::CELL_W-1:0]     sc;
  logic [tcw_pkg::ROW_W-1:0]      cur_row;
  logic [tcw_pkg::COL_W-1:0]      cur_col;
  logic [tcw_pkg::COLOR_W-1:0]    fg_color;
  logic [tcw_pkg::COLOR_W-1:0]    bg_attr;
  logic                           rd_req;
  logic [tcw_pkg::CELL_W-1:0]     rd_addr;
  logic                           copy_wr;
  logic [tcw_pkg::CELL_W-1:0]     copy_addr;

  logic [tcw_pkg::DATA_W-1:0]     mem [tcw_pkg::CELLS];
  logic [tcw_pkg::DATA_W-1:0]     rdata;
  logic                           mem_we;
  logic [tcw_pkg::CELL_W-1:0]     mem_waddr;
  logic [tcw_pkg::DATA_W-1:0]     mem_wdata;
  logic [tcw_pkg::CELL_W-1:0]     mem_raddr;

  logic                           accept;
  logic                           idx_ok;
  logic [tcw_pkg::CELL_W-1:0]     in_addr;
  logic [tcw_pkg::CELL_W-1:0]     cur_addr;
  logic                           is_nl;
  logic                           is_bs;
  logic                           at_last_col;
  logic                           at_last_row;
  logic                           need_scroll;
  logic [tcw_pkg::ROW_W-1:0]      bs_row;
  logic [tcw_pkg::COL_W-1:0]      bs_col;
  logic [tcw_pkg::CELL_W-1:0]     bs_addr;
  logic [tcw_pkg::DATA_W-1:0]     blank_cell;
  logic [tcw_pkg::DATA_W-1:0]     char_cell;
  logic [tcw_pkg::PROD_W-1:0]     div_prod;
  logic [tcw_pkg::ROW_W-1:0]      div_row;
  logic [tcw_pkg::IDX_W-1:0]      div_base;
  logic [tcw_pkg::COL_W-1:0]      div_col;

  assign accept   = in_valid && (state == tcw_pkg::S_IDLE);
  assign in_stall = (state != tcw_pkg::S_IDLE);

  assign idx_ok   = cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELLS);
  assign in_addr  = idx_ok ? cell_index[tcw_pkg::CELL_W-1:0] : '0;
  assign cur_addr = tcw_pkg::CELL_W'(cur_row * tcw_pkg::COLS) + tcw_pkg::CELL_W'(cur_col);

  assign is_nl       = (char_code == tcw_pkg::CH_NEWLINE);
  assign is_bs       = (char_code == tcw_pkg::CH_BACKSPACE);
  assign at_last_col = (cur_col == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
  assign at_last_row = (cur_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign need_scroll = !is_bs && at_last_row && (is_nl || at_last_col);

  always_comb begin
    bs_row = cur_row;
    bs_col = cur_col;
    if (cur_col != '0) begin
      bs_col = cur_col - 1'b1;
    end else if (cur_row > tcw_pkg::ROW_W'(tcw_pkg::FIXED_ROWS)) begin
      bs_row = cur_row - 1'b1;
      bs_col = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
    end
  end

  assign bs_addr    = tcw_pkg::CELL_W'(bs_row * tcw_pkg::COLS) + tcw_pkg::CELL_W'(bs_col);
  assign blank_cell = {bg_attr, fg_color, tcw_pkg::CH_SPACE};
  assign char_cell  = {bg_attr, fg_color, char_code};

  assign div_prod = tcw_pkg::PROD_W'(cell_index) * tcw_pkg::PROD_W'(tcw_pkg::DIV_MUL);
  assign div_row  = div_prod[tcw_pkg::DIV_SHIFT +: tcw_pkg::ROW_W];
  assign div_base = tcw_pkg::IDX_W'(div_row * tcw_pkg::COLS);
  assign div_col  = tcw_pkg::COL_W'(cell_index - div_base);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sc;
    mem_wdata = blank_cell;
    case (state)
      tcw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      tcw_pkg::S_IDLE: begin
        if (accept && (mode == tcw_pkg::MODE_PUT) && !is_nl) begin
          mem_we    = 1'b1;
          mem_waddr = is_bs ? bs_addr : cur_addr;
          mem_wdata = is_bs ? blank_cell : char_cell;
        end
      end
      tcw_pkg::S_FILL: begin
        mem_we = 1'b1;
      end
      tcw_pkg::S_SCROLL, tcw_pkg::S_BLANK: begin
        if (copy_wr) begin
          mem_we    = 1'b1;
          mem_waddr = copy_addr;
          mem_wdata = rdata;
        end else if (state == tcw_pkg::S_BLANK) begin
          mem_we = 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      tcw_pkg::S_SCROLL: mem_raddr = sc + tcw_pkg::CELL_W'(tcw_pkg::COLS);
      tcw_pkg::S_IDLE:   mem_raddr = in_addr;
      default:           mem_raddr = rd_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::S_INIT;
      sc        <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      fg_color  <= tcw_pkg::FG_RESET;
      bg_attr   <= tcw_pkg::BG_RESET;
      rd_req    <= 1'b0;
      copy_wr   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::REG_FG: fg_color <= cfg_data;
          tcw_pkg::REG_BG: bg_attr  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      copy_wr <= 1'b0;

      case (state)
        tcw_pkg::S_INIT: begin
          if (sc == tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1)) begin
            sc    <= '0;
            state <= tcw_pkg::S_IDLE;
          end else begin
            sc <= sc + 1'b1;
          end
        end
        tcw_pkg::S_IDLE: begin
          if (accept) begin
            rd_req  <= (mode == tcw_pkg::MODE_READ) && idx_ok;
            rd_addr <= in_addr;
            sc      <= tcw_pkg::HAS_COPY ? tcw_pkg::CELL_W'(tcw_pkg::COPY_FIRST)
                                         : tcw_pkg::CELL_W'(tcw_pkg::BLANK_FIRST);
            state   <= tcw_pkg::S_RESP;
            case (mode)
              tcw_pkg::MODE_PUT: begin
                if (is_bs) begin
                  cur_row <= bs_row;
                  cur_col <= bs_col;
                end else if (is_nl || at_last_col) begin
                  cur_col <= '0;
                  if (!at_last_row) begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else begin
                  cur_col <= cur_col + 1'b1;
                end
                if (need_scroll) begin
                  state <= tcw_pkg::HAS_COPY ? tcw_pkg::S_SCROLL : tcw_pkg::S_BLANK;
                end
              end
              tcw_pkg::MODE_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                sc      <= '0;
                state   <= tcw_pkg::S_FILL;
              end
              tcw_pkg::MODE_CURSOR: begin
                if (idx_ok) begin
                  cur_row <= div_row;
                  cur_col <= div_col;
                end
              end
              default: ;
            endcase
          end
        end
        tcw_pkg::S_FILL: begin
          if (sc == tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1)) begin
            sc    <= '0;
            state <= tcw_pkg::S_RESP;
          end else begin
            sc <= sc + 1'b1;
          end
        end
        tcw_pkg::S_SCROLL: begin
          copy_wr   <= 1'b1;
          copy_addr <= sc;
          if (sc == tcw_pkg::CELL_W'(tcw_pkg::COPY_LAST)) begin
            sc    <= tcw_pkg::CELL_W'(tcw_pkg::BLANK_FIRST);
            state <= tcw_pkg::S_BLANK;
          end else begin
            sc <= sc + 1'b1;
          end
        end
        tcw_pkg::S_BLANK: begin
          if (!copy_wr) begin
            if (sc == tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1)) begin
              sc    <= '0;
              state <= tcw_pkg::S_RESP;
            end else begin
              sc <= sc + 1'b1;
            end
          end
        end
        tcw_pkg::S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            cursor_pos <= tcw_pkg::IDX_W'(cur_addr);
            read_cell  <= rd_req ? rdata : '0;
            state      <= tcw_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tcw_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != tcw_pkg::S_IDLE)
    else $error("accepted word did not leave idle");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS) && cur_col < tcw_pkg::COL_W'(tcw_pkg::COLS))
    else $error("cursor off screen");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tcw_pkg::S_RESP))
    else $error("result loaded outside response state");

  a_copy_in_scroll: assert property (@(posedge clk) disable iff (rst)
    copy_wr |-> state == tcw_pkg::S_SCROLL || state == tcw_pkg::S_BLANK)
    else $error("scroll copy write outside scroll");

endmodule
